>>> rtl/core/sit_pkg.sv
// Package for the segment intersection test core.
// Holds the coordinate width, the derived arithmetic widths, the beat types and rule codes.
// No dependencies.
package sit_pkg;

	// Coordinate width of every input field.
	localparam int COORD_WIDTH = 16;

	// Differences of two coordinates need one extra bit.
	localparam int DIFF_W  = COORD_WIDTH + 1;
	// Product of two differences.
	localparam int PROD_W  = 2 * COORD_WIDTH + 2;
	// Cross product: difference of two products.
	localparam int CROSS_W = 2 * COORD_WIDTH + 3;
	// Denominator F - E, and the operands of the final compare.
	localparam int DEN_W   = 2 * COORD_WIDTH + 4;

	localparam int RULE_W = 3;

	// Codes naming the rule that decided the answer.
	localparam logic [RULE_W-1:0] RULE_ZERO_LEN = 3'd0;
	localparam logic [RULE_W-1:0] RULE_VERT     = 3'd1;
	localparam logic [RULE_W-1:0] RULE_HORZ     = 3'd2;
	localparam logic [RULE_W-1:0] RULE_CROSS    = 3'd3;
	localparam logic [RULE_W-1:0] RULE_MISS     = 3'd4;

	// One input beat: the end points of segments A-B and C-D.
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] ax;
		logic signed [COORD_WIDTH-1:0] ay;
		logic signed [COORD_WIDTH-1:0] bx;
		logic signed [COORD_WIDTH-1:0] by;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] dx;
		logic signed [COORD_WIDTH-1:0] dy;
	} seg_in_t;

	// One result beat.
	typedef struct packed {
		logic              hit;
		logic [RULE_W-1:0] rule;
	} seg_out_t;

endpackage

>>> rtl/core/segment_intersection_test_core.sv
// Segment intersection test core: five-stage pipeline with valid/ready on both sides.
// Depends on sit_pkg for widths, beat types and rule codes.
// Throughput: one beat per cycle; each stage holds one beat and the ready chain lets
// bubbles close up, so a stalled output only blocks once the stages behind it are full.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are not reset.
module segment_intersection_test_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sit_pkg::seg_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sit_pkg::seg_out_t out_data
);
	import sit_pkg::*;

	// Stage valid bits and per-stage ready.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// Stage 1: differences and early decisions.
	logic signed [DIFF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic                     early_s1;
	logic [RULE_W-1:0]        erule_s1;

	// Stage 2: the six products.
	logic signed [PROD_W-1:0] p_uxvy_s2, p_uyvx_s2, p_uxwy_s2, p_uywx_s2;
	logic signed [PROD_W-1:0] p_vxwy_s2, p_vywx_s2;
	logic                     early_s2;
	logic [RULE_W-1:0]        erule_s2;

	// Stage 3: cross products E, F and G.
	logic signed [CROSS_W-1:0] e_s3, f_s3, g_s3;
	logic                      early_s3;
	logic [RULE_W-1:0]         erule_s3;

	// Stage 4: denominator and sign test.
	logic signed [DEN_W-1:0] den_s4, g_s4;
	logic                    opp_s4;
	logic                    early_s4;
	logic [RULE_W-1:0]       erule_s4;

	// Stage 5: result register.
	seg_out_t res_s5;

	// Ready chain: a stage takes a beat when it is empty or its beat moves on.
	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign out_valid = v_s5;
	assign out_data  = res_s5;

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Early rules: zero length, then vertical overlap, then horizontal overlap.
	logic zero_len, vert_hit, horz_hit;
	logic early_c;
	logic [RULE_W-1:0] erule_c;

	always_comb begin
		zero_len = ((in_data.ax == in_data.bx) && (in_data.ay == in_data.by)) ||
		           ((in_data.cx == in_data.dx) && (in_data.cy == in_data.dy));
		vert_hit = (in_data.ax == in_data.bx) && (in_data.cx == in_data.dx) &&
		           (in_data.ax == in_data.cx) &&
		           (((in_data.ay >= in_data.cy) && (in_data.ay <= in_data.dy)) ||
		            ((in_data.by >= in_data.cy) && (in_data.by <= in_data.dy)));
		horz_hit = (in_data.ay == in_data.by) && (in_data.cy == in_data.dy) &&
		           (in_data.ay == in_data.cy) &&
		           (((in_data.ax >= in_data.cx) && (in_data.ax <= in_data.dx)) ||
		            ((in_data.bx >= in_data.cx) && (in_data.bx <= in_data.dx)));
		early_c = zero_len || vert_hit || horz_hit;
		priority if (zero_len) begin
			erule_c = RULE_ZERO_LEN;
		end else if (vert_hit) begin
			erule_c = RULE_VERT;
		end else if (horz_hit) begin
			erule_c = RULE_HORZ;
		end else begin
			erule_c = RULE_MISS;
		end
	end

	// Stage 1: direction u = B-A and offsets v = C-A, w = D-A.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ux_s1    <= DIFF_W'(in_data.bx) - DIFF_W'(in_data.ax);
			uy_s1    <= DIFF_W'(in_data.by) - DIFF_W'(in_data.ay);
			vx_s1    <= DIFF_W'(in_data.cx) - DIFF_W'(in_data.ax);
			vy_s1    <= DIFF_W'(in_data.cy) - DIFF_W'(in_data.ay);
			wx_s1    <= DIFF_W'(in_data.dx) - DIFF_W'(in_data.ax);
			wy_s1    <= DIFF_W'(in_data.dy) - DIFF_W'(in_data.ay);
			early_s1 <= early_c;
			erule_s1 <= erule_c;
		end
	end

	// Stage 2: one multiplier per product term, operands sign-extended first.
	logic signed [PROD_W-1:0] ux_m, uy_m, vx_m, vy_m, wx_m, wy_m;

	always_comb begin
		ux_m = PROD_W'(ux_s1);
		uy_m = PROD_W'(uy_s1);
		vx_m = PROD_W'(vx_s1);
		vy_m = PROD_W'(vy_s1);
		wx_m = PROD_W'(wx_s1);
		wy_m = PROD_W'(wy_s1);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			p_uxvy_s2 <= ux_m * vy_m;
			p_uyvx_s2 <= uy_m * vx_m;
			p_uxwy_s2 <= ux_m * wy_m;
			p_uywx_s2 <= uy_m * wx_m;
			p_vxwy_s2 <= vx_m * wy_m;
			p_vywx_s2 <= vy_m * wx_m;
			early_s2  <= early_s1;
			erule_s2  <= erule_s1;
		end
	end

	// Stage 3: E = u x v, F = u x w, G = v x w.
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			e_s3     <= CROSS_W'(p_uxvy_s2) - CROSS_W'(p_uyvx_s2);
			f_s3     <= CROSS_W'(p_uxwy_s2) - CROSS_W'(p_uywx_s2);
			g_s3     <= CROSS_W'(p_vxwy_s2) - CROSS_W'(p_vywx_s2);
			early_s3 <= early_s2;
			erule_s3 <= erule_s2;
		end
	end

	// Stage 4: denominator F - E; C and D lie on opposite sides when the signs differ.
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			den_s4   <= DEN_W'(f_s3) - DEN_W'(e_s3);
			g_s4     <= DEN_W'(g_s3);
			opp_s4   <= e_s3[CROSS_W-1] != f_s3[CROSS_W-1];
			early_s4 <= early_s3;
			erule_s4 <= erule_s3;
		end
	end

	// Stage 5: the crossing lies on A-B when G/(F-E) is within [0, 1].
	logic t_in_range;
	seg_out_t res_c;

	always_comb begin
		if (den_s4[DEN_W-1]) begin
			t_in_range = (g_s4[DEN_W-1] || (g_s4 == '0)) && (g_s4 >= den_s4);
		end else begin
			t_in_range = !g_s4[DEN_W-1] && (g_s4 <= den_s4);
		end
		priority if (early_s4) begin
			res_c.rule = erule_s4;
			res_c.hit  = (erule_s4 != RULE_ZERO_LEN);
		end else if (opp_s4 && t_in_range) begin
			res_c.rule = RULE_CROSS;
			res_c.hit  = 1'b1;
		end else begin
			res_c.rule = RULE_MISS;
			res_c.hit  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			res_s5 <= res_c;
		end
	end

	// The hit flag agrees with the rule code of every presented beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hit == ((out_data.rule == RULE_VERT) ||
		                                (out_data.rule == RULE_HORZ) ||
		                                (out_data.rule == RULE_CROSS))))
		else $error("hit flag disagrees with rule code");

	// Only defined rule codes leave the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.rule <= RULE_MISS))
		else $error("undefined rule code on output");

	// A beat held in stage 1 by a stall keeps its differences ux and wy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> (v_s1 && $stable(ux_s1) && $stable(wy_s1)))
		else $error("stage 1 beat changed while stalled");

	// An empty first stage always takes a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input refused with stage 1 empty");

endmodule
